>>> hw/rtl/plp_pkg.sv
// shared types and constants of the position p-loop with error trip
package plp_pkg;

  localparam int CMD_W    = 28;
  localparam int FB_W     = 30;
  localparam int TGT_W    = 32;
  localparam int ERR_W    = TGT_W + 1;
  localparam int MAG_W    = TGT_W;
  localparam int LIMIT_W  = 31;
  localparam int GAIN_W   = 16;
  localparam int CPR_W    = 24;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 2;
  localparam int KIND_W   = 3;
  localparam int SCALE    = 1000;
  localparam int SCALE_W  = 10;
  localparam int GAIN_FRAC = 8;
  localparam int PROD_W   = MAG_W + GAIN_W;
  localparam int NUM_W    = PROD_W + SCALE_W;
  localparam int SUM_W    = NUM_W + 1;
  localparam int QUO_W    = SUM_W - GAIN_FRAC;
  localparam int CNT_W    = $clog2(QUO_W + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(12000);
  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(2560);
  localparam logic [CPR_W-1:0]   CPR_RST   = CPR_W'(16384);

  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q8        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = CFG_IDX_W'(2);

  typedef enum logic [KIND_W-1:0] {
    K_TICK      = 3'd0,
    K_STEP      = 3'd1,
    K_CLR_TRIP  = 3'd2,
    K_CLR_DRIVE = 3'd3,
    K_START     = 3'd4,
    K_STOP      = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_RND,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

>>> hw/rtl/plp_in_if.sv
// input item channel
interface plp_in_if;
  logic                              valid;
  logic                              ready;
  logic [plp_pkg::KIND_W-1:0]        kind;
  logic signed [plp_pkg::FB_W-1:0]   reply_position;
  logic                              reply_fault_stop;
  logic                              reply_ready;
  logic signed [plp_pkg::TGT_W-1:0]  target_step;

  modport source (
    output valid, kind, reply_position, reply_fault_stop, reply_ready, target_step,
    input  ready
  );
  modport sink (
    input  valid, kind, reply_position, reply_fault_stop, reply_ready, target_step,
    output ready
  );
endinterface

>>> hw/rtl/plp_out_if.sv
// result item channel
interface plp_out_if;
  logic                              valid;
  logic                              ready;
  logic                              command_valid;
  logic signed [plp_pkg::CMD_W-1:0]  velocity_command;
  logic                              clear_faults_bit;
  logic                              tracking_fault;
  logic                              fault_stop_rise;
  logic                              ready_fall;
  logic signed [plp_pkg::TGT_W-1:0]  target_now;
  logic signed [plp_pkg::FB_W-1:0]   feedback_now;

  modport source (
    output valid, command_valid, velocity_command, clear_faults_bit, tracking_fault,
           fault_stop_rise, ready_fall, target_now, feedback_now,
    input  ready
  );
  modport sink (
    input  valid, command_valid, velocity_command, clear_faults_bit, tracking_fault,
           fault_stop_rise, ready_fall, target_now, feedback_now,
    output ready
  );
endinterface

>>> hw/rtl/plp_div.sv
// iterative restoring divider, one quotient bit per cycle
module plp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  plp_pkg::div_ctl_t           ctl,
  input  logic [plp_pkg::QUO_W-1:0]   dividend,
  input  logic [plp_pkg::CPR_W-1:0]   divisor,
  output plp_pkg::div_sts_t           sts,
  output logic [plp_pkg::QUO_W-1:0]   quotient
);
  import plp_pkg::*;

  logic [CPR_W-1:0] rem;
  logic [CPR_W-1:0] dsr;
  logic [QUO_W-1:0] qd;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [CPR_W:0]   shifted;
  logic [CPR_W+1:0] diff;
  logic             ge;

  assign shifted = {rem, qd[QUO_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};
  assign ge      = !diff[CPR_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      dsr <= divisor;
      qd  <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[CPR_W-1:0] : shifted[CPR_W-1:0];
      qd  <= {qd[QUO_W-2:0], ge};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = qd;

endmodule

>>> hw/rtl/position_p_loop_with_error_trip_unit.sv
// top level: position p-loop sequencer, state, multiply steps and output register
// a running tick that yields a command passes the multiply steps S_MUL1 and S_MUL2, the rounding
// step S_RND, the divider in S_DIV, where the quotient is saturated, and the load step S_DONE
// every other item goes from accept straight to the load step; a new item is taken only once
// the previous result is loaded, even while that result still waits in the output register
// rst is synchronous: registers go to their reset values, loop stopped, no result pending
module position_p_loop_with_error_trip_unit (
  input  logic                          clk,
  input  logic                          rst,
  plp_in_if.sink                        item_in,
  plp_out_if.source                     item_out,
  input  logic                          cfg_we,
  input  logic [plp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plp_pkg::CFG_W-1:0]     cfg_data
);
  import plp_pkg::*;

  // configuration
  logic [LIMIT_W-1:0] error_limit;
  logic [GAIN_W-1:0]  gain_q8;
  logic [CPR_W-1:0]   counts_per_rev;

  // loop state
  logic signed [TGT_W-1:0] position_target;
  logic signed [FB_W-1:0]  position_feedback;
  logic error_fault;
  logic clear_request;
  logic loop_running;
  logic last_fault_stop;
  logic last_ready;

  state_t state, state_next;

  // per-item work registers
  logic              res_cv;
  logic              res_clr;
  logic              res_rise;
  logic              res_fall;
  logic              cmd_neg;
  logic [MAG_W-1:0]  mag_r;
  logic [PROD_W-1:0] prod1;
  logic [NUM_W-1:0]  num;
  logic [CMD_W-1:0]  cmd_val;

  // output register
  logic              out_valid;
  logic              out_cv;
  logic [CMD_W-1:0]  out_cmd;
  logic              out_clr;
  logic              out_fault;
  logic              out_rise;
  logic              out_fall;
  logic [TGT_W-1:0]  out_tgt;
  logic [FB_W-1:0]   out_fb;

  logic in_fire;
  logic out_load;
  logic tick_go;

  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        err_abs;
  logic [MAG_W-1:0]        mag;
  logic                    trip;

  logic [CPR_W-1:0] cpr_eff;
  logic [SUM_W-1:0] rnd_sum;

  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic [QUO_W-1:0] div_q;

  localparam logic [QUO_W-1:0] HALF = QUO_W'(1) << (CMD_W - 1);
  logic [CMD_W-1:0] mag_sat;
  logic [CMD_W-1:0] cmd_sat;

  // error and trip check on the stored target and feedback
  assign err     = ERR_W'(position_target) - ERR_W'(position_feedback);
  assign err_abs = err[ERR_W-1] ? (ERR_W'(0) - err) : err;
  assign mag     = err_abs[MAG_W-1:0];
  assign trip    = mag > {1'b0, error_limit};

  assign in_fire = item_in.valid && item_in.ready;
  assign tick_go = (item_in.kind == K_TICK) && loop_running && !(error_fault || trip);

  // rounding: floor((num + cpr*128) / (cpr*256)) = floor(((num + cpr*128) >> 8) / cpr)
  assign cpr_eff = (counts_per_rev == '0) ? CPR_W'(1) : counts_per_rev;
  assign rnd_sum = SUM_W'(num) + SUM_W'({cpr_eff, 7'b0});

  assign mag_sat = cmd_neg ? ((div_q > HALF) ? HALF[CMD_W-1:0] : div_q[CMD_W-1:0])
                           : ((div_q > HALF - QUO_W'(1)) ? (HALF[CMD_W-1:0] - CMD_W'(1))
                                                         : div_q[CMD_W-1:0]);
  assign cmd_sat = cmd_neg ? (CMD_W'(0) - mag_sat) : mag_sat;

  plp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (rnd_sum[SUM_W-1:GAIN_FRAC]),
    .divisor  (cpr_eff),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = tick_go ? S_MUL1 : S_DONE;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_RND;
      S_RND:  state_next = S_DIV;
      S_DIV:  if (div_sts.done) state_next = S_DONE;
      S_DONE: if (!out_valid || item_out.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_in.ready = (state == S_IDLE);
    div_ctl.start = (state == S_RND);
    out_load      = (state == S_DONE) && (!out_valid || item_out.ready);
  end

  // control and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      error_limit       <= LIMIT_RST;
      gain_q8           <= GAIN_RST;
      counts_per_rev    <= CPR_RST;
      position_target   <= '0;
      position_feedback <= '0;
      error_fault       <= 1'b0;
      clear_request     <= 1'b0;
      loop_running      <= 1'b0;
      last_fault_stop   <= 1'b0;
      last_ready        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_ERROR_LIMIT:    error_limit    <= cfg_data[LIMIT_W-1:0];
          REG_GAIN_Q8:        gain_q8        <= cfg_data[GAIN_W-1:0];
          REG_COUNTS_PER_REV: counts_per_rev <= cfg_data[CPR_W-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        unique case (item_in.kind)
          K_TICK: begin
            if (loop_running) begin
              if (trip) error_fault <= 1'b1;
              clear_request     <= 1'b0;
              position_feedback <= item_in.reply_position;
              last_fault_stop   <= item_in.reply_fault_stop;
              last_ready        <= item_in.reply_ready;
            end
          end
          K_STEP: position_target <= position_target + item_in.target_step;
          K_CLR_TRIP: begin
            error_fault     <= 1'b0;
            position_target <= TGT_W'(position_feedback);
          end
          K_CLR_DRIVE: clear_request <= 1'b1;
          K_START: begin
            if (!loop_running) begin
              position_feedback <= item_in.reply_position;
              position_target   <= TGT_W'(item_in.reply_position);
              error_fault       <= 1'b0;
              loop_running      <= 1'b1;
            end
          end
          K_STOP: loop_running <= 1'b0;
          default: ;
        endcase
      end

      if (out_load) out_valid <= 1'b1;
      else if (item_out.ready) out_valid <= 1'b0;
    end
  end

  // per-item datapath and output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_cv   <= loop_running &&
                  ((item_in.kind == K_TICK) || (item_in.kind == K_STOP));
      res_clr  <= loop_running && (item_in.kind == K_TICK) && clear_request;
      res_rise <= loop_running && (item_in.kind == K_TICK) &&
                  item_in.reply_fault_stop && !last_fault_stop;
      res_fall <= loop_running && (item_in.kind == K_TICK) &&
                  !item_in.reply_ready && last_ready;
      cmd_neg  <= err[ERR_W-1];
      mag_r    <= mag;
      cmd_val  <= '0;
    end
    if (state == S_MUL1) prod1 <= PROD_W'(mag_r) * PROD_W'(gain_q8);
    if (state == S_MUL2) num <= NUM_W'(prod1) * NUM_W'(SCALE);
    if ((state == S_DIV) && div_sts.done) cmd_val <= cmd_sat;
    if (out_load) begin
      out_cv    <= res_cv;
      out_cmd   <= cmd_val;
      out_clr   <= res_clr;
      out_fault <= error_fault;
      out_rise  <= res_rise;
      out_fall  <= res_fall;
      out_tgt   <= position_target;
      out_fb    <= position_feedback;
    end
  end

  assign item_out.valid            = out_valid;
  assign item_out.command_valid    = out_cv;
  assign item_out.velocity_command = out_cmd;
  assign item_out.clear_faults_bit = out_clr;
  assign item_out.tracking_fault   = out_fault;
  assign item_out.fault_stop_rise  = out_rise;
  assign item_out.ready_fall       = out_fall;
  assign item_out.target_now       = out_tgt;
  assign item_out.feedback_now     = out_fb;

endmodule

>>> verif/tb_top.sv
// testbench for the position p-loop with error trip: directed and random items checked against a local predictor
module tb_top;
  import plp_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;
  localparam logic signed [FB_W-1:0]  FB_MAX  = {1'b0, {(FB_W-1){1'b1}}};
  localparam logic signed [FB_W-1:0]  FB_MIN  = {1'b1, {(FB_W-1){1'b0}}};
  localparam logic signed [TGT_W-1:0] TGT_MAX = {1'b0, {(TGT_W-1){1'b1}}};
  localparam logic signed [TGT_W-1:0] TGT_MIN = {1'b1, {(TGT_W-1){1'b0}}};
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
  localparam longint unsigned CMD_HALF = 64'd1 << (CMD_W - 1);
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [FB_W-1:0]   reply_position;
    logic                     reply_fault_stop;
    logic                     reply_ready;
    logic signed [TGT_W-1:0]  target_step;
  } loop_item_t;

  typedef struct {
    logic                     command_valid;
    logic signed [CMD_W-1:0]  velocity_command;
    logic                     clear_faults_bit;
    logic                     tracking_fault;
    logic                     fault_stop_rise;
    logic                     ready_fall;
    logic signed [TGT_W-1:0]  target_now;
    logic signed [FB_W-1:0]   feedback_now;
  } loop_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  plp_in_if  loop_in();
  plp_out_if loop_out();

  position_p_loop_with_error_trip_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .item_in   (loop_in),
    .item_out  (loop_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of registers and loop state
  logic [LIMIT_W-1:0]       lim_reg  = LIMIT_RST;
  logic [GAIN_W-1:0]        gain_reg = GAIN_RST;
  logic [CPR_W-1:0]         cpr_reg  = CPR_RST;
  logic signed [TGT_W-1:0]  loop_target = '0;
  logic signed [FB_W-1:0]   loop_feedback = '0;
  logic                     trip_latched = 1'b0;
  logic                     clear_pending = 1'b0;
  logic                     loop_on = 1'b0;
  logic                     prev_fault_stop = 1'b0;
  logic                     prev_ready = 1'b0;
  logic                     item_counted;

  loop_result_t predicted_replies[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  int  out_hold_cycles = 0;
  bit  burst_mode = 1'b0;
  bit  reset_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic loop_item_t make_item(input logic [KIND_W-1:0] k,
                                           input logic signed [FB_W-1:0] pos,
                                           input logic fs, input logic rdy,
                                           input logic signed [TGT_W-1:0] step);
    loop_item_t it;
    it.kind = k;
    it.reply_position = pos;
    it.reply_fault_stop = fs;
    it.reply_ready = rdy;
    it.target_step = step;
    return it;
  endfunction

  function automatic loop_result_t predict_loop_item(input loop_item_t it);
    loop_result_t r;
    longint err;
    longint unsigned mag;
    longint unsigned den;
    longint unsigned quo;
    r = '{default: '0};
    item_counted = 1'b0;
    case (it.kind)
      K_TICK: if (loop_on) begin
        err = longint'(loop_target) - longint'(loop_feedback);
        mag = (err < 0) ? unsigned'(-err) : unsigned'(err);
        if (mag > 64'(lim_reg)) trip_latched = 1'b1;
        if (!trip_latched) begin
          den = ((cpr_reg == '0) ? 64'd1 : 64'(cpr_reg)) << GAIN_FRAC;
          quo = (2 * mag * SCALE * 64'(gain_reg) + den) / (2 * den);
          if (err < 0) r.velocity_command = CMD_W'(0 - ((quo > CMD_HALF) ? CMD_HALF : quo));
          else r.velocity_command = CMD_W'((quo > CMD_HALF - 1) ? CMD_HALF - 1 : quo);
        end
        r.clear_faults_bit = clear_pending;
        clear_pending = 1'b0;
        r.command_valid = 1'b1;
        loop_feedback = it.reply_position;
        r.fault_stop_rise = it.reply_fault_stop & ~prev_fault_stop;
        r.ready_fall = ~it.reply_ready & prev_ready;
        prev_fault_stop = it.reply_fault_stop;
        prev_ready = it.reply_ready;
        item_counted = 1'b1;
      end
      K_STEP: begin
        loop_target = loop_target + it.target_step;
        item_counted = 1'b1;
      end
      K_CLR_TRIP: begin
        trip_latched = 1'b0;
        loop_target = loop_feedback;
        item_counted = 1'b1;
      end
      K_CLR_DRIVE: begin
        clear_pending = 1'b1;
        item_counted = 1'b1;
      end
      K_START: if (!loop_on) begin
        loop_feedback = it.reply_position;
        loop_target = loop_feedback;
        trip_latched = 1'b0;
        loop_on = 1'b1;
        item_counted = 1'b1;
      end
      K_STOP: if (loop_on) begin
        r.command_valid = 1'b1;
        loop_on = 1'b0;
        item_counted = 1'b1;
      end
      default: ;
    endcase
    r.tracking_fault = trip_latched;
    r.target_now = loop_target;
    r.feedback_now = loop_feedback;
    return r;
  endfunction

  task automatic send_item(input loop_item_t it);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      loop_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    loop_in.kind <= it.kind;
    loop_in.reply_position <= it.reply_position;
    loop_in.reply_fault_stop <= it.reply_fault_stop;
    loop_in.reply_ready <= it.reply_ready;
    loop_in.target_step <= it.target_step;
    loop_in.valid <= 1'b1;
    do @(posedge clk); while (!loop_in.ready);
    predicted_replies.push_back(predict_loop_item(it));
  endtask

  task automatic wait_all_replies();
    if (predicted_replies.size() != 0) begin
      loop_in.valid <= 1'b0;
      while (predicted_replies.size() != 0) @(posedge clk);
    end
  endtask

  task automatic set_loop_config(input logic [LIMIT_W-1:0] lim, input logic [GAIN_W-1:0] gain,
                                 input logic [CPR_W-1:0] cpr);
    cfg_we <= 1'b1;
    cfg_index <= REG_ERROR_LIMIT;
    cfg_data <= CFG_W'(lim);
    @(posedge clk);
    cfg_index <= REG_GAIN_Q8;
    cfg_data <= CFG_W'(gain);
    @(posedge clk);
    cfg_index <= REG_COUNTS_PER_REV;
    cfg_data <= CFG_W'(cpr);
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_reg = lim;
    gain_reg = gain;
    cpr_reg = cpr;
  endtask

  // items that a stopped loop ignores
  task automatic test_ignored_items();
    send_item(make_item(K_TICK, FB_MAX, 1'b1, 1'b1, TGT_MAX));
    send_item(make_item(KIND_UNUSED_6, FB_MIN, 1'b1, 1'b1, TGT_MIN));
    send_item(make_item(KIND_UNUSED_7, FB_MAX, 1'b0, 1'b1, TGT_MAX));
    send_item(make_item(K_STOP, FB_MIN, 1'b1, 1'b0, TGT_MIN));
    wait_all_replies();
  endtask

  // reset registers: trip, clear, rounding at one half, edges of the drive flags
  task automatic test_directed_loop();
    send_item(make_item(K_START, FB_MAX, 1'b0, 1'b0, 0));
    send_item(make_item(K_START, -5, 1'b0, 1'b0, 0));
    send_item(make_item(K_STEP, 0, 1'b0, 1'b0, TGT_MAX));
    send_item(make_item(K_TICK, FB_MIN, 1'b1, 1'b1, 0));
    send_item(make_item(K_CLR_TRIP, 0, 1'b0, 1'b0, 0));
    send_item(make_item(K_STEP, 0, 1'b0, 1'b0, 512));
    send_item(make_item(K_CLR_DRIVE, 0, 1'b0, 1'b0, 0));
    send_item(make_item(K_TICK, FB_MIN, 1'b0, 1'b0, 0));
    send_item(make_item(K_STEP, 0, 1'b0, 1'b0, -1024));
    send_item(make_item(K_TICK, FB_MIN, 1'b1, 1'b1, 0));
    send_item(make_item(K_STOP, 0, 1'b0, 1'b0, 0));
    send_item(make_item(K_TICK, 7, 1'b0, 1'b1, 0));
    wait_all_replies();
  endtask

  // saturation at both ends with zero divisor, trip one past the limit, zero limit
  task automatic test_command_saturation();
    set_loop_config(LIMIT_MAX, '1, '0);
    send_item(make_item(K_START, 0, 1'b0, 1'b0, 0));
    send_item(make_item(K_STEP, 0, 1'b0, 1'b0, TGT_MAX));
    send_item(make_item(K_TICK, 0, 1'b0, 1'b1, 0));
    send_item(make_item(K_CLR_TRIP, 0, 1'b0, 1'b0, 0));
    send_item(make_item(K_STEP, 0, 1'b0, 1'b0, TGT_MIN));
    send_item(make_item(K_TICK, 0, 1'b1, 1'b1, 0));
    send_item(make_item(K_CLR_TRIP, 0, 1'b0, 1'b0, 0));
    send_item(make_item(K_STEP, 0, 1'b0, 1'b0, TGT_MIN + 1));
    send_item(make_item(K_TICK, 0, 1'b0, 1'b0, 0));
    send_item(make_item(K_STOP, 0, 1'b0, 1'b0, 0));
    wait_all_replies();
    set_loop_config('0, GAIN_RST, CPR_RST);
    send_item(make_item(K_START, 100, 1'b0, 1'b0, 0));
    send_item(make_item(K_TICK, 100, 1'b0, 1'b1, 0));
    send_item(make_item(K_STEP, 0, 1'b0, 1'b0, 1));
    send_item(make_item(K_TICK, 100, 1'b0, 1'b1, 0));
    send_item(make_item(K_STOP, 0, 1'b0, 1'b0, 0));
    wait_all_replies();
  endtask

  // result side holds off while items keep coming, then the sender waits for all results
  task automatic test_output_backpressure();
    int n;
    wait_all_replies();
    set_loop_config(LIMIT_RST, GAIN_RST, CPR_RST);
    if (!loop_on) send_item(make_item(K_START, 1000, 1'b0, 1'b0, 0));
    out_hold_cycles = HOLD_CYCLES;
    burst_mode = 1'b1;
    for (n = 0; n < 12; n++) begin
      send_item(make_item((n % 3 == 0) ? K_STEP : K_TICK, loop_feedback + FB_W'(n),
                          1'($urandom), 1'($urandom), $urandom_range(0, 400) - 200));
    end
    burst_mode = 1'b0;
    wait_all_replies();
  endtask

  task automatic run_random_phase(input logic [LIMIT_W-1:0] lim, input logic [GAIN_W-1:0] gain,
                                  input logic [CPR_W-1:0] cpr, input bit burst, input int count);
    int counted_items;
    int pick;
    int dice;
    int delta;
    logic [KIND_W-1:0] k;
    logic signed [FB_W-1:0] pos;
    logic signed [TGT_W-1:0] step;
    wait_all_replies();
    set_loop_config(lim, gain, cpr);
    burst_mode = burst;
    counted_items = 0;
    while (counted_items < count) begin
      pick = $urandom_range(0, 99);
      if (!loop_on && pick < 60) k = K_START;
      else if (pick < 50) k = K_TICK;
      else if (pick < 68) k = K_STEP;
      else if (pick < 74) k = K_CLR_TRIP;
      else if (pick < 80) k = K_CLR_DRIVE;
      else if (pick < 86) k = K_START;
      else if (pick < 92) k = K_STOP;
      else if (pick < 96) k = $urandom_range(0, 1) ? KIND_UNUSED_6 : KIND_UNUSED_7;
      else k = KIND_W'($urandom);
      delta = $urandom_range(0, 600) - 300;
      dice = $urandom_range(0, 9);
      if (dice < 5) pos = loop_target[FB_W-1:0] + FB_W'(delta);
      else if (dice < 8) pos = loop_feedback + FB_W'(delta);
      else pos = FB_W'($urandom);
      dice = $urandom_range(0, 9);
      if (dice < 6) step = $urandom_range(0, 8000) - 4000;
      else if (dice < 9) step = $urandom_range(0, 131070) - 65535;
      else step = $urandom;
      send_item(make_item(k, pos, 1'($urandom), 1'($urandom), step));
      if (item_counted) counted_items++;
    end
    wait_all_replies();
    burst_mode = 1'b0;
  endtask

  task automatic test_random_loop();
    run_random_phase(LIMIT_RST, GAIN_RST, CPR_RST, 1'b0, 50);
    run_random_phase(LIMIT_W'($urandom_range(1, 100000)), 16'($urandom),
                     CPR_W'($urandom_range(4, 100000)), 1'b0, 55);
    run_random_phase(LIMIT_MAX, '1, 24'd4, 1'b1, 50);
    run_random_phase(LIMIT_W'($urandom_range(0, 50)), 16'($urandom), '1, 1'b0, 50);
    run_random_phase(31'($urandom), 16'($urandom), 24'($urandom), 1'b0, 55);
    run_random_phase(LIMIT_W'($urandom_range(100, 20000)), '0, 24'd1, 1'b0, 35);
    run_random_phase(LIMIT_W'($urandom_range(1000, 50000)), 16'($urandom), '0, 1'b0, 55);
  endtask

  // result checker
  initial begin
    loop_result_t want;
    int stall;
    int hold;
    int reply_index;
    reply_index = 0;
    wait (reset_done);
    forever begin
      if (out_hold_cycles > 0) begin
        hold = out_hold_cycles;
        out_hold_cycles = 0;
        loop_out.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      stall = burst_mode ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        loop_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      loop_out.ready <= 1'b1;
      do @(posedge clk); while (!loop_out.valid);
      reply_index++;
      if (predicted_replies.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no item pending", reply_index));
      end else begin
        want = predicted_replies.pop_front();
        check_field("command_valid", loop_out.command_valid, want.command_valid);
        check_field("velocity_command", loop_out.velocity_command, want.velocity_command);
        check_field("clear_faults_bit", loop_out.clear_faults_bit, want.clear_faults_bit);
        check_field("tracking_fault", loop_out.tracking_fault, want.tracking_fault);
        check_field("fault_stop_rise", loop_out.fault_stop_rise, want.fault_stop_rise);
        check_field("ready_fall", loop_out.ready_fall, want.ready_fall);
        check_field("target_now", loop_out.target_now, want.target_now);
        check_field("feedback_now", loop_out.feedback_now, want.feedback_now);
      end
    end
  end

  always @(posedge clk) begin
    if (!reset_done || (loop_in.valid && loop_in.ready) || (loop_out.valid && loop_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_ERROR_LIMIT;
    cfg_data <= '0;
    loop_in.valid <= 1'b0;
    loop_in.kind <= K_TICK;
    loop_in.reply_position <= '0;
    loop_in.reply_fault_stop <= 1'b0;
    loop_in.reply_ready <= 1'b0;
    loop_in.target_step <= '0;
    loop_out.ready <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    reset_done = 1'b1;
    test_ignored_items();
    test_directed_loop();
    test_command_saturation();
    test_output_backpressure();
    test_random_loop();
    wait_all_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_replies.size() != 0) flag_error("expected results left over");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
